[rtl/assert_macros.svh]
// Assertion macros shared by the median filter RTL.
// Each use needs clk and rst in scope; reset disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MF_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("median filter assertion failed");

// Same-cycle implication.
`define MF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("median filter assertion failed");

// Next-cycle implication.
`define MF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("median filter assertion failed");

`endif

[rtl/mf_pkg.sv]
// Package for the 3x3 median filter: sizes, item types, register indexes
// and the compare-exchange helpers used by the sorting stages. No dependencies.
`timescale 1ns / 1ps

package mf_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int MIN_SIZE     = 3;
  localparam int WIN_SIZE     = 3;
  localparam int PIX_W        = 8;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = CFG_WIDTH_W'(640);
  localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = CFG_HEIGHT_W'(480);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One window column, top row first.
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } trio_t;

  // Position of a filtered pixel.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } mf_pos_t;

  // Queue entry: full 3x3 window, oldest column at index 0.
  typedef struct packed {
    column_t [WIN_SIZE-1:0] win;
    mf_pos_t                pos;
  } mf_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mf_q_status_t;

  // Three-element sorting network.
  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t  x0;
    pix_t  x1;
    pix_t  x2;
    pix_t  t;
    trio_t r;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t  = x0;
      x0 = x1;
      x1 = t;
    end
    if (x1 > x2) begin
      t  = x1;
      x1 = x2;
      x2 = t;
    end
    if (x0 > x1) begin
      t  = x0;
      x0 = x1;
      x1 = t;
    end
    r.lo = x0;
    r.md = x1;
    r.hi = x2;
    return r;
  endfunction

endpackage

[rtl/mf_ifs.sv]
// Valid/ready channel interfaces of the median filter: pixel input,
// result output and configuration write. Depends on mf_pkg.
`timescale 1ns / 1ps

interface mf_pixel_if import mf_pkg::*; ();
  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface mf_result_if import mf_pkg::*; ();
  logic             valid;
  logic             ready;
  pix_t             median;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_last;

  modport source (output valid, output median, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input median, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

interface mf_cfg_if import mf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mf_front.sv]
// Front end: config registers, raster position tracking, line store and
// 3x3 window; pushes interior windows to the queue. Depends on mf_pkg, mf_ifs.
`timescale 1ns / 1ps

module mf_front import mf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  mf_pixel_if.sink pixels,
  mf_cfg_if.sink   cfg,
  output logic     push,
  output mf_item_t push_item,
  input  logic     q_full
);

  logic [CFG_WIDTH_W-1:0]  frame_width;
  logic [CFG_HEIGHT_W-1:0] frame_height;
  logic [CFG_WIDTH_W-1:0]  w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic                    c_wrap;
  logic [CFG_HEIGHT_W-1:0] r_inc;
  logic [COL_W-1:0]        c0;
  logic [ROW_W-1:0]        r0;
  logic [CFG_WIDTH_W-1:0]  c_next;
  logic [CFG_HEIGHT_W-1:0] r_n;
  logic                    wrap_end;

  logic             f1_valid;
  pix_t             f1_pix;
  logic [ROW_W-1:0] f1_row;
  logic [COL_W-1:0] f1_col;
  logic             f1_res;
  logic             f1_last;
  logic             f1_adv;
  logic             acc;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data;
  column_t            new_col;
  column_t            win [WIN_SIZE];

  // Configuration writes; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg.data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < CFG_WIDTH_W'(MIN_SIZE))
      w_eff = CFG_WIDTH_W'(MIN_SIZE);
    else if (frame_width > CFG_WIDTH_W'(MAX_WIDTH))
      w_eff = CFG_WIDTH_W'(MAX_WIDTH);
    else
      w_eff = frame_width;
    if (frame_height < CFG_HEIGHT_W'(MIN_SIZE))
      h_eff = CFG_HEIGHT_W'(MIN_SIZE);
    else if (frame_height > CFG_HEIGHT_W'(MAX_HEIGHT))
      h_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
    else
      h_eff = frame_height;
  end

  // Position of the incoming pixel; a shrunk size wraps a stale count first.
  always_comb begin
    c_wrap   = {1'b0, col_count} >= w_eff;
    c0       = c_wrap ? '0 : col_count;
    r_inc    = {1'b0, row_count} + CFG_HEIGHT_W'(c_wrap);
    r0       = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    c_next   = {1'b0, c0} + CFG_WIDTH_W'(1);
    r_n      = {1'b0, r0} + CFG_HEIGHT_W'(1);
    wrap_end = c_next >= w_eff;
    if (wrap_end) begin
      col_count_next = '0;
      row_count_next = (r_n >= h_eff) ? '0 : r_n[ROW_W-1:0];
    end else begin
      col_count_next = c_next[COL_W-1:0];
      row_count_next = r0;
    end
  end

  // F1 holds one pixel while its line store read completes.
  assign f1_adv       = f1_valid && (!f1_res || !q_full);
  assign pixels.ready = !f1_valid || f1_adv;
  assign acc          = pixels.valid && pixels.ready;
  assign push         = f1_valid && f1_res && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      f1_valid  <= 1'b0;
    end else begin
      if (acc) begin
        col_count <= col_count_next;
        row_count <= row_count_next;
      end
      if (acc)
        f1_valid <= 1'b1;
      else if (f1_adv)
        f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1_pix  <= pixels.pixel;
      f1_row  <= r0;
      f1_col  <= c0;
      f1_res  <= (r0 >= ROW_W'(WIN_SIZE - 1)) && (c0 >= COL_W'(WIN_SIZE - 1));
      f1_last <= ({1'b0, r0} == h_eff - CFG_HEIGHT_W'(1)) &&
                 ({1'b0, c0} == w_eff - CFG_WIDTH_W'(1));
    end
  end

  // Line store entry: {row two above, row above}. Read holds while F1 stalls.
  always_ff @(posedge clk) begin
    if (f1_adv)
      line_mem[f1_col] <= {rd_data[PIX_W-1:0], f1_pix};
    if (acc)
      rd_data <= line_mem[c0];
  end

  assign new_col.top = rd_data[2*PIX_W-1:PIX_W];
  assign new_col.mid = rd_data[PIX_W-1:0];
  assign new_col.bot = f1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_SIZE; i++)
        win[i] <= '0;
    end else if (f1_adv) begin
      for (int i = 0; i < WIN_SIZE - 1; i++)
        win[i] <= win[i+1];
      win[WIN_SIZE-1] <= new_col;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_SIZE - 1; i++)
      push_item.win[i] = win[i+1];
    push_item.win[WIN_SIZE-1] = new_col;
    push_item.pos.row  = f1_row - ROW_W'(1);
    push_item.pos.col  = f1_col - COL_W'(1);
    push_item.pos.last = f1_last;
  end

endmodule

[rtl/mf_queue.sv]
// Short FIFO of window items between the front end and the median pipeline.
// Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_queue import mf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  mf_item_t     push_item,
  input  logic         pop,
  output mf_item_t     head,
  output mf_q_status_t status
);

  mf_item_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push)
      entries[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/mf_back.sv]
// Back end: three-stage median-of-nine network (sort columns, reduce
// lows/mids/highs, median of three) ending in the output register. Depends on mf_pkg, mf_ifs.
`timescale 1ns / 1ps

module mf_back import mf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  mf_item_t      head,
  input  mf_q_status_t  q_stat,
  output logic          pop,
  mf_result_if.source   results
);

  logic    en;
  trio_t   s1_sorted [WIN_SIZE];
  trio_t   s1_next   [WIN_SIZE];
  logic    s1_valid;
  mf_pos_t s1_pos;
  trio_t   lows;
  trio_t   mids;
  trio_t   highs;
  pix_t    s2_lo;
  pix_t    s2_md;
  pix_t    s2_hi;
  logic    s2_valid;
  mf_pos_t s2_pos;
  trio_t   fin;
  logic    out_valid;

  // Whole pipeline moves together; it only holds when the output is stalled.
  assign en  = !out_valid || results.ready;
  assign pop = en && !q_stat.empty;

  always_comb begin
    for (int k = 0; k < WIN_SIZE; k++)
      s1_next[k] = sort3(head.win[k].top, head.win[k].mid, head.win[k].bot);
    lows  = sort3(s1_sorted[0].lo, s1_sorted[1].lo, s1_sorted[2].lo);
    mids  = sort3(s1_sorted[0].md, s1_sorted[1].md, s1_sorted[2].md);
    highs = sort3(s1_sorted[0].hi, s1_sorted[1].hi, s1_sorted[2].hi);
    // Median of nine = median of (max of lows, median of mids, min of highs).
    fin   = sort3(s2_lo, s2_md, s2_hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !q_stat.empty;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < WIN_SIZE; k++)
        s1_sorted[k] <= s1_next[k];
      s1_pos <= head.pos;
      s2_lo  <= lows.hi;
      s2_md  <= mids.md;
      s2_hi  <= highs.lo;
      s2_pos <= s1_pos;
      results.median     <= fin.md;
      results.out_row    <= s2_pos.row;
      results.out_col    <= s2_pos.col;
      results.frame_last <= s2_pos.last;
    end
  end

  assign results.valid = out_valid;

endmodule

[rtl/median_filter_3x3.sv]
// 3x3 median filter over a raster pixel stream, one result per interior pixel.
// Throughput: one pixel per cycle while the output is not stalled, set by the
// line store (one read and one write port per cycle) feeding a 4-entry queue
// and a 3-stage sorting pipeline.
// Reset: clears position counters, window, queue and pipeline; size returns to
// 640x480. Line store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module median_filter_3x3 import mf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mf_pixel_if.sink    pixels,
  mf_result_if.source results,
  mf_cfg_if.sink      cfg
);

  logic         q_push;
  logic         q_pop;
  mf_item_t     q_in;
  mf_item_t     q_head;
  mf_q_status_t q_stat;

  mf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .pixels    (pixels),
    .cfg       (cfg),
    .push      (q_push),
    .push_item (q_in),
    .q_full    (q_stat.full)
  );

  mf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_stat)
  );

  mf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_stat  (q_stat),
    .pop     (q_pop),
    .results (results)
  );

  `MF_ASSERT(a_q_full_empty, !(q_stat.full && q_stat.empty))
  `MF_ASSERT_IMPLY(a_no_push_full, q_stat.full, !q_push)
  `MF_ASSERT_IMPLY(a_no_pop_empty, q_pop, !q_stat.empty)
  `MF_ASSERT_IMPLY(a_hold_on_stall, results.valid && !results.ready, !q_pop)
  `MF_ASSERT_IMPLY(a_interior_only, results.valid,
                   results.out_row != '0 && results.out_col != '0)

endmodule
